// File: hw/rtl/rwlt_pkg.sv
// ----------------------------------------------------------------------------
// Reader/writer lock table package
// Shared types, codes and constants of the lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

    localparam int LockSlotsDefault = 32;
    localparam int WaitDepthDefault = 8;
    localparam int QueueDepth       = 4;

    typedef enum logic [2:0] {
        OP_CREATE       = 3'd0,
        OP_READ_LOCK    = 3'd1,
        OP_WRITE_LOCK   = 3'd2,
        OP_READ_UNLOCK  = 3'd3,
        OP_WRITE_UNLOCK = 3'd4,
        OP_DELETE       = 3'd5,
        OP_STOP         = 3'd6,
        OP_NONE         = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        RC_CREATED       = 4'd0,
        RC_TABLE_FULL    = 4'd1,
        RC_READ_GRANTED  = 4'd2,
        RC_WRITE_GRANTED = 4'd3,
        RC_NOT_FOUND     = 4'd4,
        RC_RUNLOCK_REF   = 4'd5,
        RC_READ_UNLOCKED = 4'd6,
        RC_WRITE_UNLOCKED = 4'd7,
        RC_DELETE_BUSY   = 4'd8,
        RC_DELETED       = 4'd9,
        RC_STOPPED       = 4'd10,
        RC_QUEUE_FULL    = 4'd11
    } t_code;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] lock_id;
        logic [15:0] requester_id;
    } t_req;

    typedef struct packed {
        logic [15:0] reply_to;
        logic        success;
        logic [3:0]  reply_code;
        logic        last;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EXEC,
        ST_DRAIN_RD,
        ST_DRAIN_WAIT,
        ST_REPLY
    } t_state;

endpackage

// File: hw/rtl/reader_writer_lock_table.sv
// ----------------------------------------------------------------------------
// Reader/writer lock table
// Request beats in, reply beats out; one request is carried out at a time.
// ----------------------------------------------------------------------------
// Requests (operation, lock id, requester id) arrive on the i_valid/o_ready
// channel and land in a four-entry queue, so the sender is held off only when
// that queue is full. Requests after a stop are taken and discarded.
// Replies leave on o_valid/i_ready, one beat each, with last set on the
// final beat that a request causes. An unlock sends one grant beat per woken
// waiter, oldest first, before its own reply.
// Each request leaves the queue, then scans up to LOCK_SLOTS slots (the scan
// stops just after the first matching slot, or after the first free slot for
// a create), and is then carried out. An unlock that wakes waiters passes
// through a read state and a wait state for each waiter, then a reply state
// for its own reply.
// A stalled receiver holds the reply register and the back end waits; the
// front queue keeps taking requests until it is full.
// Reset clears all slots, wait counts and the stopped flag at once.
// ----------------------------------------------------------------------------
module reader_writer_lock_table
    import rwlt_pkg::*;
#(
    parameter int LOCK_SLOTS = LockSlotsDefault,
    parameter int WAIT_DEPTH = WaitDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic q_valid, q_ready;
    t_req q_req;

    rwlt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_req   (q_req)
    );

    rwlt_back #(
        .LOCK_SLOTS (LOCK_SLOTS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_req   (q_req),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp     (o_rsp)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("reply changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.reply_code <= RC_QUEUE_FULL)
        else $error("reply code out of range");

    a_grant_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.last |-> o_rsp.success &&
        (o_rsp.reply_code == RC_READ_GRANTED || o_rsp.reply_code == RC_WRITE_GRANTED))
        else $error("non-final beat is not a grant");

endmodule

// File: hw/rtl/rwlt_front.sv
// ----------------------------------------------------------------------------
// Lock table front end
// Accepts request beats, drops them after a stop or when they carry no operation, and queues the rest.
// ----------------------------------------------------------------------------
module rwlt_front
    import rwlt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_q_valid,
    input  logic i_q_ready,
    output t_req o_q_req
);

    localparam int Aw = $clog2(QueueDepth);

    t_req           r_mem [QueueDepth];
    logic [Aw-1:0]  r_wp, r_rp;
    logic [Aw:0]    r_cnt;
    logic           r_stopped;
    logic           w_acc, w_push, w_pop, w_drop;

    assign o_ready   = (r_cnt != (Aw+1)'(QueueDepth));
    assign w_acc     = i_valid && o_ready;
    assign w_drop    = r_stopped || (t_op'(i_req.operation) == OP_NONE);
    assign w_push    = w_acc && !w_drop;
    assign o_q_valid = (r_cnt != '0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == Aw'(QueueDepth-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == Aw'(QueueDepth-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(w_push) - (Aw+1)'(w_pop);
            if (w_push && t_op'(i_req.operation) == OP_STOP) begin
                r_stopped <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/rwlt_back.sv
// ----------------------------------------------------------------------------
// Lock table back end
// Searches the slots, updates mode and wait queues, and emits reply beats.
// ----------------------------------------------------------------------------
module rwlt_back
    import rwlt_pkg::*;
#(
    parameter int LOCK_SLOTS = LockSlotsDefault,
    parameter int WAIT_DEPTH = WaitDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    output logic o_q_ready,
    input  t_req i_q_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam int Sw = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int Cw = $clog2(WAIT_DEPTH + 1);
    localparam int Jw = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int Mw = Sw + Jw;
    localparam int Md = LOCK_SLOTS * WAIT_DEPTH;

    t_state         r_state, n_state;
    t_req           r_req;
    logic [Sw:0]    r_idx;
    logic           r_found, r_free_found;
    logic [Sw-1:0]  r_slot, r_free;
    logic [Cw-1:0]  r_j, r_n;
    logic           r_drain_wr;
    logic           r_vld;
    t_rsp           r_rsp;

    logic [LOCK_SLOTS-1:0] r_valid;
    logic [15:0]    r_id   [LOCK_SLOTS];
    t_mode          r_mode [LOCK_SLOTS];
    logic [Cw-1:0]  r_rcnt [LOCK_SLOTS];
    logic [Cw-1:0]  r_wcnt [LOCK_SLOTS];
    logic [15:0]    r_rq   [Md];
    logic [15:0]    r_wq   [Md];
    logic [15:0]    r_rd_data;

    logic [Sw-1:0]  w_idx;
    logic           w_out_free;
    t_mode          w_mode;
    logic [Cw-1:0]  w_rc, w_wc;
    logic           w_q_wr_en, w_q_wr_wr;
    logic [Mw-1:0]  w_q_wa, w_q_ra;
    logic           w_emit;
    t_rsp           w_rsp;
    t_op            w_op;

    assign w_idx      = r_idx[Sw-1:0];
    assign w_out_free = !r_vld || i_ready;
    assign w_mode     = r_mode[r_slot];
    assign w_rc       = r_rcnt[r_slot];
    assign w_wc       = r_wcnt[r_slot];
    assign w_op       = t_op'(r_req.operation);
    assign o_q_ready  = (r_state == ST_IDLE);
    assign o_valid    = r_vld;
    assign o_rsp      = r_rsp;
    assign w_q_wa     = Mw'(r_slot) * Mw'(WAIT_DEPTH)
                      + Mw'(w_op == OP_READ_LOCK ? w_rc : w_wc);
    assign w_q_ra     = Mw'(r_slot) * Mw'(WAIT_DEPTH) + Mw'(r_j);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_idx == (Sw+1)'(LOCK_SLOTS - 1)
                    || (w_op == OP_CREATE ? r_free_found : r_found)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                    if (r_found && (w_op == OP_READ_UNLOCK || w_op == OP_WRITE_UNLOCK)
                        && !(w_op == OP_READ_UNLOCK && w_mode == MODE_WRITE)
                        && (w_rc != '0 || w_wc != '0)) begin
                        n_state = ST_DRAIN_RD;
                    end
                end
            end
            ST_DRAIN_RD: begin
                n_state = ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT: begin
                if (w_out_free) begin
                    n_state = (r_j + 1'b1 == r_n) ? ST_REPLY : ST_DRAIN_RD;
                end
            end
            ST_REPLY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_emit    = 1'b0;
        w_rsp     = '{reply_to: r_req.requester_id, success: 1'b1,
                      reply_code: RC_CREATED, last: 1'b1};
        w_q_wr_en = 1'b0;
        w_q_wr_wr = 1'b0;
        unique case (r_state)
            ST_EXEC: begin
                w_emit = w_out_free;
                if (w_op == OP_CREATE) begin
                    if (!r_free_found) begin
                        w_rsp.success    = 1'b0;
                        w_rsp.reply_code = RC_TABLE_FULL;
                    end
                end else if (w_op == OP_STOP) begin
                    w_rsp.reply_code = RC_STOPPED;
                end else if (!r_found) begin
                    w_rsp.success    = 1'b0;
                    w_rsp.reply_code = RC_NOT_FOUND;
                end else begin
                    unique case (w_op)
                        OP_READ_LOCK: begin
                            if (w_mode == MODE_WRITE) begin
                                if (w_rc >= Cw'(WAIT_DEPTH)) begin
                                    w_rsp.success    = 1'b0;
                                    w_rsp.reply_code = RC_QUEUE_FULL;
                                end else begin
                                    w_emit    = 1'b0;
                                    w_q_wr_en = w_out_free;
                                end
                            end else begin
                                w_rsp.reply_code = RC_READ_GRANTED;
                            end
                        end
                        OP_WRITE_LOCK: begin
                            if (w_mode == MODE_FREE) begin
                                w_rsp.reply_code = RC_WRITE_GRANTED;
                            end else if (w_wc >= Cw'(WAIT_DEPTH)) begin
                                w_rsp.success    = 1'b0;
                                w_rsp.reply_code = RC_QUEUE_FULL;
                            end else begin
                                w_emit    = 1'b0;
                                w_q_wr_en = w_out_free;
                                w_q_wr_wr = 1'b1;
                            end
                        end
                        OP_READ_UNLOCK: begin
                            if (w_mode == MODE_WRITE) begin
                                w_rsp.success    = 1'b0;
                                w_rsp.reply_code = RC_RUNLOCK_REF;
                            end else begin
                                w_rsp.reply_code = RC_READ_UNLOCKED;
                                w_emit = w_out_free && w_rc == '0 && w_wc == '0;
                            end
                        end
                        OP_WRITE_UNLOCK: begin
                            w_rsp.reply_code = RC_WRITE_UNLOCKED;
                            w_emit = w_out_free && w_rc == '0 && w_wc == '0;
                        end
                        default: begin
                            if (w_mode != MODE_FREE) begin
                                w_rsp.success    = 1'b0;
                                w_rsp.reply_code = RC_DELETE_BUSY;
                            end else begin
                                w_rsp.reply_code = RC_DELETED;
                            end
                        end
                    endcase
                end
            end
            ST_DRAIN_WAIT: begin
                w_emit           = w_out_free;
                w_rsp.reply_to   = r_rd_data;
                w_rsp.reply_code = r_drain_wr ? RC_WRITE_GRANTED : RC_READ_GRANTED;
                w_rsp.last       = 1'b0;
            end
            ST_REPLY: begin
                w_emit           = w_out_free;
                w_rsp.reply_code = (w_op == OP_READ_UNLOCK) ? RC_READ_UNLOCKED
                                                            : RC_WRITE_UNLOCKED;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_q_wr_en && !w_q_wr_wr) begin
            r_rq[w_q_wa] <= r_req.requester_id;
        end
        if (w_q_wr_en && w_q_wr_wr) begin
            r_wq[w_q_wa] <= r_req.requester_id;
        end
        r_rd_data <= r_drain_wr ? r_wq[w_q_ra] : r_rq[w_q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_rsp <= w_rsp;
        end
        if (r_state == ST_IDLE && i_q_valid) begin
            r_req <= i_q_req;
        end
        if (r_state == ST_SEARCH) begin
            if (r_valid[w_idx] && r_id[w_idx] == r_req.lock_id && !r_found) begin
                r_slot <= w_idx;
            end
            if (!r_valid[w_idx] && !r_free_found) begin
                r_free <= w_idx;
            end
        end
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vld        <= 1'b0;
            r_valid      <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_j          <= '0;
            r_n          <= '0;
            r_drain_wr   <= 1'b0;
            for (int i = 0; i < LOCK_SLOTS; i++) begin
                r_rcnt[i] <= '0;
                r_wcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_idx        <= '0;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                end
                ST_SEARCH: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_valid[w_idx] && r_id[w_idx] == r_req.lock_id) begin
                        r_found <= 1'b1;
                    end
                    if (!r_valid[w_idx]) begin
                        r_free_found <= 1'b1;
                    end
                end
                ST_EXEC: begin
                    if (w_out_free) begin
                        if (w_op == OP_CREATE) begin
                            if (r_free_found) begin
                                r_valid[r_free] <= 1'b1;
                                r_id[r_free]    <= r_req.lock_id;
                                r_mode[r_free]  <= MODE_FREE;
                                r_rcnt[r_free]  <= '0;
                                r_wcnt[r_free]  <= '0;
                            end
                        end else if (r_found) begin
                            r_j <= '0;
                            unique case (w_op)
                                OP_READ_LOCK: begin
                                    if (w_mode != MODE_WRITE) begin
                                        r_mode[r_slot] <= MODE_READ;
                                    end else if (w_q_wr_en) begin
                                        r_rcnt[r_slot] <= w_rc + 1'b1;
                                    end
                                end
                                OP_WRITE_LOCK: begin
                                    if (w_mode == MODE_FREE) begin
                                        r_mode[r_slot] <= MODE_WRITE;
                                    end else if (w_q_wr_en) begin
                                        r_wcnt[r_slot] <= w_wc + 1'b1;
                                    end
                                end
                                OP_READ_UNLOCK, OP_WRITE_UNLOCK: begin
                                    if (!(w_op == OP_READ_UNLOCK && w_mode == MODE_WRITE))
                                    begin
                                        if (w_rc == '0 && w_wc == '0) begin
                                            r_mode[r_slot] <= MODE_FREE;
                                        end else if ((w_op == OP_WRITE_UNLOCK && w_wc != '0)
                                                  || w_rc == '0) begin
                                            r_drain_wr     <= 1'b1;
                                            r_n            <= w_wc;
                                            r_wcnt[r_slot] <= '0;
                                            r_mode[r_slot] <= MODE_WRITE;
                                        end else begin
                                            r_drain_wr     <= 1'b0;
                                            r_n            <= w_rc;
                                            r_rcnt[r_slot] <= '0;
                                            r_mode[r_slot] <= MODE_READ;
                                        end
                                    end
                                end
                                OP_DELETE: begin
                                    if (w_mode == MODE_FREE) begin
                                        r_valid[r_slot] <= 1'b0;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                ST_DRAIN_WAIT: begin
                    if (w_out_free) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
